>>> design/stf_pkg.sv
// Shared constants, register codes and tap weight function of the triangle filter.
package stf_pkg;

    localparam int DEF_MAX_RADIUS = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int RADIUS_W   = 4;
    localparam int CENTER_W   = 16;
    localparam int NORM_W     = 25;
    localparam int DIM_W      = 11;
    localparam int PIXEL_W    = 16;
    localparam int VALUE_W    = 24;
    localparam int TAP_W      = 16;
    localparam int COLSUM_W   = 33;
    localparam int TOTAL_W    = 49;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    localparam int RST_RADIUS = 1;
    localparam int RST_CENTER = 512;
    localparam int RST_NORM   = 1048576;
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 24'hFFFFFF;

    // weight of tap at distance a for radius r
    function automatic logic [TAP_W-1:0] tap_weight(
        input logic [RADIUS_W-1:0] r,
        input logic [RADIUS_W-1:0] a,
        input logic [CENTER_W-1:0] center
    );
        logic [RADIUS_W:0] span;
        begin
            span = {1'b0, r} + 5'd1 - {1'b0, a};
            if (r == 4'd1)
            begin
                tap_weight = (a == 4'd0) ? center : 16'd256;
            end
            else
            begin
                tap_weight = 16'({span, 8'd0});
            end
        end
    endfunction

endpackage

>>> design/separable_triangle_filter_2d_top.sv
// Streaming 2D separable triangle filter with mirrored borders.
//
// Input channel (in_valid/in_stall, func, pixel): pixels in raster order
// (func 0) or drain items (func 1). Output channel (out_valid/out_stall):
// value, end_of_row, end_of_frame, dropped, last per result item.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
// One item is worked on at a time; in_stall is high while busy.
// A pixel item that is not dropped writes the line store and then releases
// 0..radius+1 outputs. Each output makes one line store read per tap for the
// vertical pass, then passes through the column-sum chain for the horizontal
// pass, then the scaling states NORM1 and NORM2. A pixel that releases nothing
// passes the check and advance states; a dropped pixel the drop state.
// Reset clears positions and flags and loads register defaults; the line
// store is not cleared (never read before written in a frame).
// When the receiver stalls, the result in the output register waits there and
// the sequencer holds the next finished result until that one is taken.
module separable_triangle_filter_2d_top #(
    parameter int MAX_RADIUS = stf_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = stf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = stf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [stf_pkg::PIXEL_W-1:0]     pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [stf_pkg::VALUE_W-1:0]     value,
    output logic                            end_of_row,
    output logic                            end_of_frame,
    output logic                            dropped,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(RING);
    localparam int CPW   = $clog2(MAX_WIDTH);
    localparam int RPW   = $clog2(MAX_HEIGHT);
    localparam int GW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int GX    = GW + 1;
    localparam int HX    = HW + 1;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CSW   = stf_pkg::COLSUM_W;
    localparam int TW    = stf_pkg::TOTAL_W;
    localparam int RW    = stf_pkg::RADIUS_W;
    localparam int HPW   = TW - 32 + stf_pkg::NORM_W;
    localparam int LPW   = 32 + stf_pkg::NORM_W;
    localparam int RSW   = HPW + 1;

    localparam int RST_R = (stf_pkg::RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS : stf_pkg::RST_RADIUS;
    localparam int RST_W = (stf_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : stf_pkg::RST_WIDTH;
    localparam int RST_H = (stf_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : stf_pkg::RST_HEIGHT;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_PRE   = 4'd2;
    localparam logic [3:0] S_VERT  = 4'd3;
    localparam logic [3:0] S_VWAIT = 4'd4;
    localparam logic [3:0] S_HOR   = 4'd5;
    localparam logic [3:0] S_HWAIT = 4'd6;
    localparam logic [3:0] S_NORM1 = 4'd7;
    localparam logic [3:0] S_NORM2 = 4'd8;
    localparam logic [3:0] S_SEND  = 4'd9;
    localparam logic [3:0] S_DROP  = 4'd10;
    localparam logic [3:0] S_ADV   = 4'd11;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (s == SW'(RING - 1)) ? '0 : s + SW'(1);
    endfunction

    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
        slot_dec = (s == '0) ? SW'(RING - 1) : s - SW'(1);
    endfunction

    // configuration
    logic [RW-1:0]                   radius_reg;
    logic [stf_pkg::CENTER_W-1:0]    center_reg;
    logic [stf_pkg::NORM_W-1:0]      norm_reg;
    logic [stf_pkg::DIM_W-1:0]       width_cfg_reg;
    logic [stf_pkg::DIM_W-1:0]       height_cfg_reg;

    // frame geometry and positions
    logic [RW-1:0]  geo_r_reg;
    logic [GW-1:0]  geo_w_reg;
    logic [HW-1:0]  geo_h_reg;
    logic [RW-1:0]  lat_r;
    logic [GW-1:0]  lat_w;
    logic [HW-1:0]  lat_h;
    logic [RPW-1:0] in_row_reg;
    logic [CPW-1:0] in_col_reg;
    logic [SW-1:0]  in_slot_reg;
    logic [RPW-1:0] out_row_reg;
    logic [CPW-1:0] out_col_reg;
    logic [SW-1:0]  out_slot_reg;
    logic           fr_reg;
    logic           kind_reg;
    logic           eof_seen_reg;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       start_walk;
    logic       in_acc;
    logic       slot_free;

    // walkers
    logic [RPW-1:0] rw_m_reg;
    logic           rw_d_reg;
    logic [SW-1:0]  rw_slot_reg;
    logic [RPW-1:0] rs_m_reg;
    logic           rs_d_reg;
    logic [SW-1:0]  rs_slot_reg;
    logic [CPW-1:0] cw_m_reg;
    logic           cw_d_reg;
    logic [RPW-1:0] rw_m_step;
    logic           rw_d_step;
    logic [SW-1:0]  rw_slot_step;
    logic [CPW-1:0] cw_m_step;
    logic           cw_d_step;
    logic           walk_up;
    logic [RW-1:0]  cnt_reg;
    logic [SW-1:0]  kv_reg;
    logic [SW-1:0]  kh_reg;
    logic [SW-1:0]  hj_reg;
    logic [SW-1:0]  two_r;
    logic           kv_last;
    logic           kh_last;
    logic [RW-1:0]  a_v;
    logic [RW-1:0]  a_h;

    // datapath
    logic [stf_pkg::PIXEL_W-1:0] rd_data;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic                        v1_reg;
    logic                        first1_reg;
    logic                        last1_reg;
    logic [stf_pkg::TAP_W-1:0]   tap1_reg;
    logic                        v2_reg;
    logic                        first2_reg;
    logic                        last2_reg;
    logic [31:0]                 prod2_reg;
    logic [CSW-1:0]              acc_reg;
    logic [CSW-1:0]              col_sum;
    logic                        chain_en;
    logic [CSW-1:0]              chain_in;
    logic [CSW-1:0]              cell_q [RING];
    logic                        hv_reg;
    logic                        hfirst_reg;
    logic [TW-1:0]               hprod_reg;
    logic [TW-1:0]               total_reg;
    logic [HPW-1:0]              hp_reg;
    logic [LPW-1:0]              lp_reg;
    logic [LPW:0]                rnd;
    logic [RSW-1:0]              res;
    logic [stf_pkg::VALUE_W-1:0] hold_value_reg;
    logic                        hold_eor_reg;
    logic                        hold_eof_reg;

    // conditions
    logic [HX-1:0] need_row;
    logic [GX-1:0] need_col_raw;
    logic [GX-1:0] need_col;
    logic [GX-1:0] w_last;
    logic          cond;
    logic          more;
    logic          at_origin;
    logic          eor;
    logic          eof;
    logic          in_eor;
    logic          in_eof;

    // output register
    logic                        out_valid_reg;
    logic [stf_pkg::VALUE_W-1:0] value_reg;
    logic                        end_of_row_reg;
    logic                        end_of_frame_reg;
    logic                        dropped_reg;
    logic                        last_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        lat_r = (32'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_reg;
        if (width_cfg_reg == '0)
        begin
            lat_w = GW'(1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            lat_w = GW'(MAX_WIDTH);
        end
        else
        begin
            lat_w = GW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0)
        begin
            lat_h = HW'(1);
        end
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
        begin
            lat_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            lat_h = HW'(height_cfg_reg);
        end
    end

    always_comb
    begin
        need_row     = HX'(out_row_reg) + HX'(geo_r_reg);
        need_col_raw = GX'(out_col_reg) + GX'(geo_r_reg);
        w_last       = GX'(geo_w_reg) - GX'(1);
        need_col     = (need_col_raw > w_last) ? w_last : need_col_raw;
        cond = (need_row < HX'(geo_h_reg)) && !fr_reg
            && !((need_row > HX'(in_row_reg))
                 || ((need_row == HX'(in_row_reg)) && (need_col > GX'(in_col_reg))));
        at_origin = (out_row_reg == '0) && (out_col_reg == '0);
        more      = cond && !at_origin;
        eor    = (GX'(out_col_reg) + GX'(1)) >= GX'(geo_w_reg);
        eof    = eor && ((HX'(out_row_reg) + HX'(1)) >= HX'(geo_h_reg));
        in_eor = (GX'(in_col_reg) + GX'(1)) >= GX'(geo_w_reg);
        in_eof = (HX'(in_row_reg) + HX'(1)) >= HX'(geo_h_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        start_walk = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (func)
                    begin
                        if (fr_reg)
                        begin
                            state_next = S_PRE;
                            start_walk = 1'b1;
                        end
                    end
                    else if (fr_reg)
                    begin
                        state_next = S_DROP;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (cond)
                begin
                    state_next = S_PRE;
                    start_walk = 1'b1;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_PRE:
            begin
                if (cnt_reg == geo_r_reg)
                begin
                    state_next = S_VERT;
                end
            end
            S_VERT:
            begin
                if (kv_last && kh_last)
                begin
                    state_next = S_VWAIT;
                end
            end
            S_VWAIT:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = S_HOR;
                end
            end
            S_HOR:
            begin
                if (hj_reg == two_r)
                begin
                    state_next = S_HWAIT;
                end
            end
            S_HWAIT:
            begin
                if (!hv_reg)
                begin
                    state_next = S_NORM1;
                end
            end
            S_NORM1:
            begin
                state_next = S_NORM2;
            end
            S_NORM2:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    if (kind_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (more)
                    begin
                        state_next = S_PRE;
                        start_walk = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_DROP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADV:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            radius_reg     <= RW'(stf_pkg::RST_RADIUS);
            center_reg     <= stf_pkg::CENTER_W'(stf_pkg::RST_CENTER);
            norm_reg       <= stf_pkg::NORM_W'(stf_pkg::RST_NORM);
            width_cfg_reg  <= stf_pkg::DIM_W'(stf_pkg::RST_WIDTH);
            height_cfg_reg <= stf_pkg::DIM_W'(stf_pkg::RST_HEIGHT);
            geo_r_reg      <= RW'(RST_R);
            geo_w_reg      <= GW'(RST_W);
            geo_h_reg      <= HW'(RST_H);
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_slot_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_slot_reg   <= '0;
            fr_reg         <= 1'b0;
            kind_reg       <= 1'b0;
            eof_seen_reg   <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            hv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == S_VERT);
            v2_reg    <= v1_reg;
            hv_reg    <= (state_reg == S_HOR);

            if (cfg_valid)
            begin
                case (cfg_index)
                    stf_pkg::REG_RADIUS: radius_reg     <= cfg_data[RW-1:0];
                    stf_pkg::REG_CENTER: center_reg     <= cfg_data[stf_pkg::CENTER_W-1:0];
                    stf_pkg::REG_NORM:   norm_reg       <= cfg_data[stf_pkg::NORM_W-1:0];
                    stf_pkg::REG_WIDTH:  width_cfg_reg  <= cfg_data[stf_pkg::DIM_W-1:0];
                    stf_pkg::REG_HEIGHT: height_cfg_reg <= cfg_data[stf_pkg::DIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_acc)
            begin
                kind_reg     <= func;
                eof_seen_reg <= 1'b0;
                if (!func && !fr_reg && (in_row_reg == '0) && (in_col_reg == '0)
                    && (out_row_reg == '0) && (out_col_reg == '0))
                begin
                    geo_r_reg <= lat_r;
                    geo_w_reg <= lat_w;
                    geo_h_reg <= lat_h;
                end
            end

            // advance output position as the result is finished
            if (state_reg == S_NORM2)
            begin
                if (eof)
                begin
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_slot_reg <= '0;
                    fr_reg       <= 1'b0;
                    eof_seen_reg <= 1'b1;
                end
                else if (eor)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + RPW'(1);
                    out_slot_reg <= slot_inc(out_slot_reg);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CPW'(1);
                end
            end

            if (state_reg == S_ADV)
            begin
                if (in_eor)
                begin
                    in_col_reg <= '0;
                    if (in_eof)
                    begin
                        in_row_reg  <= '0;
                        in_slot_reg <= '0;
                        fr_reg <= (!at_origin || (geo_r_reg != '0)) && !eof_seen_reg;
                    end
                    else
                    begin
                        in_row_reg  <= in_row_reg + RPW'(1);
                        in_slot_reg <= slot_inc(in_slot_reg);
                    end
                end
                else
                begin
                    in_col_reg <= in_col_reg + CPW'(1);
                end
            end

            if ((state_reg == S_SEND) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if ((state_reg == S_DROP) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SEND) && slot_free)
        begin
            value_reg        <= hold_value_reg;
            end_of_row_reg   <= hold_eor_reg;
            end_of_frame_reg <= hold_eof_reg;
            dropped_reg      <= 1'b0;
            last_reg         <= kind_reg || !more;
        end
        else if ((state_reg == S_DROP) && slot_free)
        begin
            value_reg        <= '0;
            end_of_row_reg   <= 1'b0;
            end_of_frame_reg <= 1'b0;
            dropped_reg      <= 1'b1;
            last_reg         <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign end_of_row   = end_of_row_reg;
    assign end_of_frame = end_of_frame_reg;
    assign dropped      = dropped_reg;
    assign last         = last_reg;

    // mirrored walkers over rows and columns
    assign walk_up = (state_reg == S_VERT);
    assign two_r   = SW'({geo_r_reg, 1'b0});
    assign kv_last = (kv_reg == two_r);
    assign kh_last = (kh_reg == two_r);

    stf_mirror_step #(.IW(RPW), .NW(HW)) u_row_step (
        .pos      (rw_m_reg),
        .dir      (rw_d_reg),
        .size     (geo_h_reg),
        .up       (walk_up),
        .pos_next (rw_m_step),
        .dir_next (rw_d_step)
    );

    stf_mirror_step #(.IW(CPW), .NW(GW)) u_col_step (
        .pos      (cw_m_reg),
        .dir      (cw_d_reg),
        .size     (geo_w_reg),
        .up       (walk_up),
        .pos_next (cw_m_step),
        .dir_next (cw_d_step)
    );

    always_comb
    begin
        if (rw_m_step > rw_m_reg)
        begin
            rw_slot_step = slot_inc(rw_slot_reg);
        end
        else if (rw_m_step < rw_m_reg)
        begin
            rw_slot_step = slot_dec(rw_slot_reg);
        end
        else
        begin
            rw_slot_step = rw_slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_walk)
        begin
            rw_m_reg    <= out_row_reg;
            rw_d_reg    <= 1'b1;
            rw_slot_reg <= out_slot_reg;
            cw_m_reg    <= out_col_reg;
            cw_d_reg    <= 1'b1;
            cnt_reg     <= '0;
        end
        else if (state_reg == S_PRE)
        begin
            if (cnt_reg == geo_r_reg)
            begin
                rs_m_reg    <= rw_m_reg;
                rs_d_reg    <= rw_d_reg;
                rs_slot_reg <= rw_slot_reg;
                kv_reg      <= '0;
                kh_reg      <= '0;
            end
            else
            begin
                rw_m_reg    <= rw_m_step;
                rw_d_reg    <= rw_d_step;
                rw_slot_reg <= rw_slot_step;
                cw_m_reg    <= cw_m_step;
                cw_d_reg    <= cw_d_step;
                cnt_reg     <= cnt_reg + RW'(1);
            end
        end
        else if (state_reg == S_VERT)
        begin
            if (kv_last)
            begin
                kv_reg      <= '0;
                kh_reg      <= kh_reg + SW'(1);
                rw_m_reg    <= rs_m_reg;
                rw_d_reg    <= rs_d_reg;
                rw_slot_reg <= rs_slot_reg;
                cw_m_reg    <= cw_m_step;
                cw_d_reg    <= cw_d_step;
            end
            else
            begin
                kv_reg      <= kv_reg + SW'(1);
                rw_m_reg    <= rw_m_step;
                rw_d_reg    <= rw_d_step;
                rw_slot_reg <= rw_slot_step;
            end
        end
    end

    // line store
    assign wr_en   = in_acc && !func && !fr_reg;
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign rd_addr = AW'(rw_slot_reg) * AW'(MAX_WIDTH) + AW'(cw_m_reg);

    stf_line_store #(.DEPTH(DEPTH), .AW(AW)) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pixel),
        .rd_en   (walk_up),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // vertical pass
    always_comb
    begin
        a_v = (5'(kv_reg) >= {1'b0, geo_r_reg}) ? RW'(5'(kv_reg) - {1'b0, geo_r_reg})
                                                 : RW'({1'b0, geo_r_reg} - 5'(kv_reg));
        a_h = (5'(hj_reg) >= {1'b0, geo_r_reg}) ? RW'(5'(hj_reg) - {1'b0, geo_r_reg})
                                                 : RW'({1'b0, geo_r_reg} - 5'(hj_reg));
        col_sum  = (first2_reg ? '0 : acc_reg) + CSW'(prod2_reg);
        chain_en = (v2_reg && last2_reg) || (state_reg == S_HOR);
        chain_in = (state_reg == S_HOR) ? '0 : col_sum;
    end

    always_ff @(posedge clk)
    begin
        tap1_reg   <= stf_pkg::tap_weight(geo_r_reg, a_v, center_reg);
        first1_reg <= (kv_reg == '0);
        last1_reg  <= kv_last;
        prod2_reg  <= 32'(tap1_reg) * 32'(rd_data);
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        if (v2_reg)
        begin
            acc_reg <= col_sum;
        end
    end

    // column-sum chain
    for (genvar i = 0; i < RING; i++)
    begin : g_cells
        stf_cell #(.DW(CSW)) u_cell (
            .clk   (clk),
            .shift (chain_en),
            .d     ((i == 0) ? chain_in : cell_q[(i == 0) ? 0 : i - 1]),
            .q     (cell_q[i])
        );
    end

    // horizontal pass and scaling
    always_ff @(posedge clk)
    begin
        if (state_reg == S_VWAIT)
        begin
            hj_reg <= '0;
        end
        else if (state_reg == S_HOR)
        begin
            hj_reg <= hj_reg + SW'(1);
        end
        hprod_reg  <= TW'(stf_pkg::tap_weight(geo_r_reg, a_h, center_reg)) * TW'(cell_q[two_r]);
        hfirst_reg <= (hj_reg == '0);
        if (hv_reg)
        begin
            total_reg <= (hfirst_reg ? '0 : total_reg) + hprod_reg;
        end
        if (state_reg == S_NORM1)
        begin
            hp_reg <= HPW'(total_reg[TW-1:32]) * HPW'(norm_reg);
            lp_reg <= LPW'(total_reg[31:0]) * LPW'(norm_reg);
        end
        if (state_reg == S_NORM2)
        begin
            hold_value_reg <= (res > RSW'(stf_pkg::VALUE_MAX)) ? stf_pkg::VALUE_MAX
                                                                : res[stf_pkg::VALUE_W-1:0];
            hold_eor_reg   <= eor;
            hold_eof_reg   <= eof;
        end
    end

    always_comb
    begin
        rnd = (LPW+1)'(lp_reg) + (LPW+1)'(33'h080000000);
        res = RSW'(hp_reg) + RSW'(rnd[LPW:32]);
    end

    a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dropped_reg |-> last_reg && (value_reg == '0) && !end_of_frame_reg)
        else $error("dropped result malformed");

    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_of_frame_reg |-> end_of_row_reg)
        else $error("end of frame without end of row");

    a_received_origin: assert property (@(posedge clk) disable iff (!rst_n)
        fr_reg |-> (in_row_reg == '0) && (in_col_reg == '0))
        else $error("frame received with input position not at origin");

endmodule

>>> design/stf_cell.sv
// One cell of the column-sum chain: holds a column sum, takes its neighbor's on shift.
module stf_cell #(
    parameter int DW = stf_pkg::COLSUM_W
) (
    input  logic          clk,
    input  logic          shift,
    input  logic [DW-1:0] d,
    output logic [DW-1:0] q
);

    logic [DW-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

>>> design/stf_mirror_step.sv
// One step of a mirrored index walk (edge reflection, folds repeatedly).
module stf_mirror_step #(
    parameter int IW = 10,
    parameter int NW = 11
) (
    input  logic [IW-1:0] pos,
    input  logic          dir,
    input  logic [NW-1:0] size,
    input  logic          up,
    output logic [IW-1:0] pos_next,
    output logic          dir_next
);

    logic [IW-1:0] top_idx;

    always_comb
    begin
        top_idx  = IW'(size - NW'(1));
        pos_next = pos;
        dir_next = dir;
        if (up == dir)
        begin
            // moving toward the upper edge
            if (pos == top_idx)
            begin
                dir_next = ~dir;
            end
            else
            begin
                pos_next = pos + IW'(1);
            end
        end
        else
        begin
            if (pos == '0)
            begin
                dir_next = ~dir;
            end
            else
            begin
                pos_next = pos - IW'(1);
            end
        end
    end

endmodule

>>> design/stf_line_store.sv
// Line store ring: one write port, one registered read port.
module stf_line_store #(
    parameter int DEPTH = 17408,
    parameter int AW    = 15
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [stf_pkg::PIXEL_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [stf_pkg::PIXEL_W-1:0] rd_data
);

    logic [stf_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [stf_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
